// ===== sv/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// Depends on nothing; used by sv/i2c_master_byte_engine_top.sv.
package i2cmbe_pkg;

  // Field widths.
  localparam int unsigned DelayW   = 16;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned BitCntW  = 3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;

  // Register reset values.
  localparam logic [DelayW-1:0]   DELAY_TICKS_RESET = 16'd360;
  localparam logic [TimeoutW-1:0] ACK_TIMEOUT_RESET = 16'd250;

  // Last bit position of a byte (bits are counted 0..7).
  localparam logic [BitCntW-1:0] LAST_BIT = 3'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DELAY_TICKS = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT = 8'd1;

  // Command codes.
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // Bus phases of the sequencer, one-hot.
  typedef enum logic [17:0] {
    PH_IDLE    = 18'h00001,
    PH_ST1     = 18'h00002,
    PH_ST2     = 18'h00004,
    PH_ST3     = 18'h00008,
    PH_SP1     = 18'h00010,
    PH_SP2     = 18'h00020,
    PH_WB_SET  = 18'h00040,
    PH_WB_HI   = 18'h00080,
    PH_WB_LO   = 18'h00100,
    PH_WA_REL  = 18'h00200,
    PH_WA_HI   = 18'h00400,
    PH_WA_POLL = 18'h00800,
    PH_WA_LO   = 18'h01000,
    PH_RB_LO   = 18'h02000,
    PH_RB_HI   = 18'h04000,
    PH_RK_SET  = 18'h08000,
    PH_RK_HI   = 18'h10000,
    PH_RK_LO   = 18'h20000
  } phase_t;

  // One result word.
  typedef struct packed {
    logic             ack_missing;
    logic [ByteW-1:0] rx_byte;
    logic             done_res;
    logic             busy_res;
    logic             sda_drive;
    logic             sda_out;
    logic             scl_out;
  } result_t;

endpackage

// ===== sv/i2c_master_byte_engine_top.sv =====
// I2C master byte engine: bit-level bus sequencer for start, stop, write and read.
// A result word is registered into the output stage when its input word is accepted.
// Throughput: one input word per cycle while the skid entry is free; the sequencer state advances once per word.
// A two-entry output stage lets one more input word in while a result waits to be taken.
// Reset (rst, synchronous): sequencer idle, SCL and SDA high and driven, registers
// back to delay_ticks 360 and ack_timeout 250, output stage empty.
// Depends on sv/i2cmbe_pkg.sv.
module i2c_master_byte_engine_top (
  input  logic                               clk,
  input  logic                               rst,
  // Input words.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [i2cmbe_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] cmd_valid, [2:1] func
  input  logic [i2cmbe_pkg::InUserW-1:0]     s_axis_tuser,
  // Result words.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_missing, [15:14] zero
  output logic [i2cmbe_pkg::OutDataW-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [i2cmbe_pkg::CfgDataW-1:0]    cfg_data
);

  // Configuration registers.
  logic [i2cmbe_pkg::DelayW-1:0]   delay_ticks;
  logic [i2cmbe_pkg::TimeoutW-1:0] ack_timeout;

  // Sequencer state.
  i2cmbe_pkg::phase_t               phase, phase_next, ph;
  logic [i2cmbe_pkg::BitCntW-1:0]   bit_count, bit_count_next;
  logic [i2cmbe_pkg::ByteW-1:0]     shift_reg, shift_reg_next;
  logic [i2cmbe_pkg::DelayW-1:0]    delay_count, delay_count_next;
  logic [i2cmbe_pkg::TimeoutW-1:0]  poll_count, poll_count_next;
  logic                             ack_choice, ack_choice_next;
  logic                             scl_line, scl_line_next;
  logic                             sda_line, sda_line_next;
  logic                             drv_line, drv_line_next;
  logic                             ack_missing, ack_missing_next;
  logic [i2cmbe_pkg::ByteW-1:0]     rx_hold, rx_hold_next;

  // Output stage: main register and skid entry.
  logic                             out_valid, skid_valid;
  i2cmbe_pkg::result_t              out_data, skid_data, res;

  // Input word fields.
  logic                             cmd_valid, send_ack, sda_in;
  i2cmbe_pkg::func_t                func;
  logic [i2cmbe_pkg::ByteW-1:0]     tx_byte;
  logic                             s_accept, m_accept, busy, done, phase_end;

  assign cmd_valid = s_axis_tuser[0];
  assign func      = i2cmbe_pkg::func_t'(s_axis_tuser[2:1]);
  assign tx_byte   = s_axis_tdata[7:0];
  assign send_ack  = s_axis_tdata[8];
  assign sda_in    = s_axis_tdata[9];

  assign s_axis_tready = !skid_valid;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(i2cmbe_pkg::OutDataW - $bits(i2cmbe_pkg::result_t)){1'b0}},
                          out_data};
  assign cfg_ready     = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cmbe_pkg::DELAY_TICKS_RESET;
      ack_timeout <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == i2cmbe_pkg::REG_DELAY_TICKS) begin
        delay_ticks <= cfg_data[i2cmbe_pkg::DelayW-1:0];
      end else if (cfg_index == i2cmbe_pkg::REG_ACK_TIMEOUT) begin
        ack_timeout <= cfg_data[i2cmbe_pkg::TimeoutW-1:0];
      end
    end
  end

  // One sequencer tick per accepted word.
  always_comb begin
    ph               = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    ack_choice_next  = ack_choice;
    scl_line_next    = scl_line;
    sda_line_next    = sda_line;
    drv_line_next    = drv_line;
    ack_missing_next = ack_missing;
    rx_hold_next     = rx_hold;
    busy             = 1'b0;
    done             = 1'b0;
    phase_end        = 1'b0;

    // An idle engine takes a command; this tick is its first phase tick.
    if (phase == i2cmbe_pkg::PH_IDLE && cmd_valid) begin
      delay_count_next = '0;
      bit_count_next   = '0;
      case (func)
        i2cmbe_pkg::FUNC_START: ph = i2cmbe_pkg::PH_ST1;
        i2cmbe_pkg::FUNC_STOP:  ph = i2cmbe_pkg::PH_SP1;
        i2cmbe_pkg::FUNC_WRITE: begin
          ph               = i2cmbe_pkg::PH_WB_SET;
          shift_reg_next   = tx_byte;
          ack_missing_next = 1'b0;
        end
        default: begin
          ph              = i2cmbe_pkg::PH_RB_LO;
          shift_reg_next  = '0;
          ack_choice_next = send_ack;
        end
      endcase
    end

    phase_next = ph;

    if (ph != i2cmbe_pkg::PH_IDLE) begin
      busy = 1'b1;

      // Line levels for the current phase; SDA holds its value when released.
      unique case (ph) inside
        i2cmbe_pkg::PH_ST1, i2cmbe_pkg::PH_SP2: begin
          scl_line_next = 1'b1; sda_line_next = 1'b1; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_ST2: begin
          scl_line_next = 1'b1; sda_line_next = 1'b0; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_ST3, i2cmbe_pkg::PH_SP1: begin
          scl_line_next = 1'b0; sda_line_next = 1'b0; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_WB_SET: begin
          scl_line_next = 1'b0; sda_line_next = shift_reg_next[7]; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_WB_HI: begin
          scl_line_next = 1'b1; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_WB_LO: begin
          scl_line_next = 1'b0; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_WA_REL, i2cmbe_pkg::PH_WA_LO, i2cmbe_pkg::PH_RB_LO: begin
          scl_line_next = 1'b0; drv_line_next = 1'b0;
        end
        i2cmbe_pkg::PH_WA_HI, i2cmbe_pkg::PH_WA_POLL, i2cmbe_pkg::PH_RB_HI: begin
          scl_line_next = 1'b1; drv_line_next = 1'b0;
        end
        i2cmbe_pkg::PH_RK_SET, i2cmbe_pkg::PH_RK_LO: begin
          scl_line_next = 1'b0; sda_line_next = !ack_choice_next; drv_line_next = 1'b1;
        end
        i2cmbe_pkg::PH_RK_HI: begin
          scl_line_next = 1'b1; sda_line_next = !ack_choice_next; drv_line_next = 1'b1;
        end
        default: begin
        end
      endcase

      if (ph == i2cmbe_pkg::PH_WA_POLL) begin
        // Acknowledge poll: one sample per tick.
        if (!sda_in) begin
          phase_next       = i2cmbe_pkg::PH_WA_LO;
          delay_count_next = '0;
        end else if (poll_count >= ack_timeout) begin
          ack_missing_next = 1'b1;
          phase_next       = i2cmbe_pkg::PH_SP1;
          delay_count_next = '0;
        end else begin
          poll_count_next = poll_count + 1'b1;
        end
      end else begin
        // Read bits are sampled on the first tick of the SCL high phase.
        if (ph == i2cmbe_pkg::PH_RB_HI && delay_count_next == '0) begin
          shift_reg_next = {shift_reg_next[i2cmbe_pkg::ByteW-2:0], sda_in};
        end
        phase_end = ({1'b0, delay_count_next} + 17'd1) >= {1'b0, delay_ticks};
        if (phase_end) begin
          delay_count_next = '0;
          unique case (ph)
            i2cmbe_pkg::PH_ST1:    phase_next = i2cmbe_pkg::PH_ST2;
            i2cmbe_pkg::PH_ST2:    phase_next = i2cmbe_pkg::PH_ST3;
            i2cmbe_pkg::PH_SP1:    phase_next = i2cmbe_pkg::PH_SP2;
            i2cmbe_pkg::PH_WB_SET: phase_next = i2cmbe_pkg::PH_WB_HI;
            i2cmbe_pkg::PH_WB_HI:  phase_next = i2cmbe_pkg::PH_WB_LO;
            i2cmbe_pkg::PH_WB_LO: begin
              if (bit_count_next == i2cmbe_pkg::LAST_BIT) begin
                phase_next = i2cmbe_pkg::PH_WA_REL;
              end else begin
                bit_count_next = bit_count_next + 1'b1;
                shift_reg_next = {shift_reg_next[i2cmbe_pkg::ByteW-2:0], 1'b0};
                phase_next     = i2cmbe_pkg::PH_WB_SET;
              end
            end
            i2cmbe_pkg::PH_WA_REL: phase_next = i2cmbe_pkg::PH_WA_HI;
            i2cmbe_pkg::PH_WA_HI: begin
              phase_next      = i2cmbe_pkg::PH_WA_POLL;
              poll_count_next = '0;
            end
            i2cmbe_pkg::PH_RB_LO:  phase_next = i2cmbe_pkg::PH_RB_HI;
            i2cmbe_pkg::PH_RB_HI: begin
              if (bit_count_next == i2cmbe_pkg::LAST_BIT) begin
                phase_next = i2cmbe_pkg::PH_RK_SET;
              end else begin
                bit_count_next = bit_count_next + 1'b1;
                phase_next     = i2cmbe_pkg::PH_RB_LO;
              end
            end
            i2cmbe_pkg::PH_RK_SET: phase_next = i2cmbe_pkg::PH_RK_HI;
            i2cmbe_pkg::PH_RK_HI:  phase_next = i2cmbe_pkg::PH_RK_LO;
            i2cmbe_pkg::PH_RK_LO: begin
              rx_hold_next = shift_reg_next;
              phase_next   = i2cmbe_pkg::PH_IDLE;
              done         = 1'b1;
            end
            default: begin
              // End of start, end of stop, end of acknowledged write.
              phase_next = i2cmbe_pkg::PH_IDLE;
              done       = 1'b1;
            end
          endcase
        end else begin
          delay_count_next = delay_count_next + 1'b1;
        end
      end
    end

    res.scl_out     = scl_line_next;
    res.sda_out     = sda_line_next;
    res.sda_drive   = drv_line_next;
    res.busy_res    = busy;
    res.done_res    = done;
    res.rx_byte     = rx_hold_next;
    res.ack_missing = ack_missing_next;
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2cmbe_pkg::PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      delay_count <= '0;
      poll_count  <= '0;
      ack_choice  <= 1'b0;
      scl_line    <= 1'b1;
      sda_line    <= 1'b1;
      drv_line    <= 1'b1;
      ack_missing <= 1'b0;
      rx_hold     <= '0;
    end else if (s_accept) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      poll_count  <= poll_count_next;
      ack_choice  <= ack_choice_next;
      scl_line    <= scl_line_next;
      sda_line    <= sda_line_next;
      drv_line    <= drv_line_next;
      ack_missing <= ack_missing_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // Output stage: a result goes to the main register when it is free,
  // otherwise to the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_accept) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (s_accept) begin
        out_data <= res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (s_accept) begin
      if (!out_valid) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  // The skid entry is only used behind a full main register.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a word while the main register is empty");

  // A word with no command on an idle engine reports an idle bus.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && phase == i2cmbe_pkg::PH_IDLE && !cmd_valid) |-> (!res.busy_res && !res.done_res))
    else $error("idle engine reported activity");

  // A finished command always returns the engine to idle.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && res.done_res) |=> (phase == i2cmbe_pkg::PH_IDLE))
    else $error("command finished but engine not idle");

  // During the acknowledge poll SCL is high and SDA is released.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && phase == i2cmbe_pkg::PH_WA_POLL) |-> (res.scl_out && !res.sda_drive))
    else $error("bus lines wrong during acknowledge poll");

endmodule
